// ----- rtl/core/bqc_pkg.sv -----
// Package for the two-section cascaded biquad filter.
// Holds sample and coefficient widths, register indexes, reset values and sequencer states.
// No dependencies.
package bqc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned StepW   = 4;

  localparam logic [StepW-1:0] LastStep = StepW'(8);
  localparam logic [StepW-1:0] Sec0Done = StepW'(4);
  localparam logic [StepW-1:0] Sec1Start = StepW'(5);
  localparam logic [StepW-1:0] FirstAdd = StepW'(1);

  localparam logic [CfgIdxW-1:0] IdxFfCoef1 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] IdxFfCoef2 = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] IdxFbCoef1 = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] IdxFbCoef2 = CfgIdxW'(3);

  localparam logic [SampleW-1:0] RstFfCoef1 = 16'sd128;
  localparam logic [SampleW-1:0] RstFfCoef2 = 16'sd64;
  localparam logic [SampleW-1:0] RstFbCoef1 = 16'sd128;
  localparam logic [SampleW-1:0] RstFbCoef2 = -16'sd64;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMac  = 3'b010,
    StFin  = 3'b100
  } state_e;

endpackage

// ----- rtl/core/biquad_cascade_two_stage.sv -----
// Two-section cascaded biquad filter, Q8.8 samples, one shared 16x16 multiplier.
// Depends on bqc_pkg.
//
// Each sample passes these phases up to its result being loaded into the
// output register: its transfer in, the multiply-accumulate steps in which
// the single 16x16 multiplier and its registered product feed one 32-bit
// accumulator (eight products, both sections), and a finishing state that
// shifts the delay lines and loads the result.
// Input stall is high after the transfer in until the result is loaded, including
// while a finished result cannot be loaded because the previous one still waits,
// stalled, in the output register. The coefficient port is always ready;
// write it only while the filter is idle.
module biquad_cascade_two_stage import bqc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SampleW-1:0]  sample_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SampleW-1:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [SampleW-1:0] ff1_q, ff2_q, fb1_q, fb2_q;
  logic [SampleW-1:0] in_h_q  [4];
  logic [SampleW-1:0] out_h_q [4];
  logic [SampleW-1:0] x_q, y0_q;
  logic [AccW-1:0]    prod_q, acc_q, acc_d;
  logic [SampleW-1:0] out_q;
  logic               out_valid_q;

  logic               in_xfer, out_free, fin_load;
  logic [SampleW-1:0] mul_a, mul_b;
  logic signed [AccW-1:0] prod_full;
  logic [1:0]         base;

  assign in_stall_o   = (state_q != StIdle);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign fin_load     = (state_q == StFin) && out_free;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign cfg_ready_o  = 1'b1;

  // operand select: cnt[2] picks the section, cnt[1:0] the tap
  assign base = {cnt_q[2], 1'b0};
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin mul_a = ff1_q; mul_b = in_h_q[base];         end
      2'd1: begin mul_a = ff2_q; mul_b = in_h_q[base | 2'd1];  end
      2'd2: begin mul_a = fb1_q; mul_b = out_h_q[base];        end
      default: begin mul_a = fb2_q; mul_b = out_h_q[base | 2'd1]; end
    endcase
  end

  assign prod_full = $signed(mul_a) * $signed(mul_b);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StMac;
          cnt_d   = '0;
        end
      end
      StMac: begin
        if (cnt_q == FirstAdd || cnt_q == Sec1Start) acc_d = prod_q;
        else if (cnt_q != '0)                        acc_d = acc_q + prod_q;
        if (cnt_q == LastStep) state_d = StFin;
        else                   cnt_d   = cnt_q + StepW'(1);
      end
      StFin: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ff1_q       <= RstFfCoef1;
      ff2_q       <= RstFfCoef2;
      fb1_q       <= RstFbCoef1;
      fb2_q       <= RstFbCoef2;
      for (int i = 0; i < 4; i++) begin
        in_h_q[i]  <= '0;
        out_h_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (fin_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          IdxFfCoef1: ff1_q <= cfg_data_i;
          IdxFfCoef2: ff2_q <= cfg_data_i;
          IdxFbCoef1: fb1_q <= cfg_data_i;
          IdxFbCoef2: fb2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fin_load) begin
        in_h_q[1]  <= in_h_q[0];
        in_h_q[0]  <= x_q;
        out_h_q[1] <= out_h_q[0];
        out_h_q[0] <= y0_q;
        in_h_q[3]  <= in_h_q[2];
        in_h_q[2]  <= y0_q;
        out_h_q[3] <= out_h_q[2];
        out_h_q[2] <= acc_q[8 +: SampleW];
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) x_q <= sample_in_i;
    prod_q <= prod_full;
    acc_q  <= acc_d;
    if (state_q == StMac && cnt_q == Sec0Done) y0_q <= acc_d[8 +: SampleW];
    if (fin_load) out_q <= acc_q[8 +: SampleW];
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == StMac) && (cnt_q == '0))
    else $error("transfer in did not start the sequencer");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMac) |-> (cnt_q <= LastStep))
    else $error("step counter overran");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) && out_valid_q && out_stall_i |=> (state_q == StFin))
    else $error("result dropped while output register was full");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> out_valid_q && (state_q == StIdle))
    else $error("result not presented after load");

endmodule
